// ===== rtl/core/avt_pkg.sv =====
// ----------------------------------------------------------------------------
// avt_pkg
// Shared types and codes of the aging visit table: record layout, result
// status codes, operation codes and the compare unit's result group.
// ----------------------------------------------------------------------------
package avt_pkg;

    localparam int KEY_W   = 31;
    localparam int YEAR_W  = 16;
    localparam int VCNT_W  = 32;
    localparam int STAT_W  = 2;
    localparam int OCNT_W  = 7;

    localparam logic [YEAR_W-1:0] RESET_YEAR = 16'd2016;

    // operation codes carried on the input tuser
    localparam logic OP_VISIT = 1'b0;
    localparam logic OP_PURGE = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_HIT  = 2'd0;
    localparam logic [STAT_W-1:0] ST_NEW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // one table record
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [YEAR_W-1:0] year;
        logic [VCNT_W-1:0] vcnt;
    } t_rec;

    // compare unit results
    typedef struct packed {
        logic              key_hit;
        logic              too_old;
        logic [VCNT_W-1:0] vcnt_next;
    } t_unit_res;

endpackage

// ===== rtl/core/avt_mem.sv =====
// ----------------------------------------------------------------------------
// avt_mem
// Record memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module avt_mem #(
    parameter int ENTRIES = 64,
    parameter int IW      = 6
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [IW-1:0]   i_waddr,
    input  avt_pkg::t_rec   i_wdata,
    input  logic            i_re,
    input  logic [IW-1:0]   i_raddr,
    output avt_pkg::t_rec   o_rdata
);

    avt_pkg::t_rec r_mem [ENTRIES];
    avt_pkg::t_rec r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/avt_unit.sv =====
// ----------------------------------------------------------------------------
// avt_unit
// Shared compare unit: key match, signed age test and saturating count
// increment on the record just read from memory.
// ----------------------------------------------------------------------------
module avt_unit (
    input  avt_pkg::t_rec                       i_rec,
    input  logic [avt_pkg::KEY_W-1:0]           i_key,
    input  logic [avt_pkg::YEAR_W-1:0]          i_cur_year,
    input  logic [avt_pkg::YEAR_W-1:0]          i_max_age,
    output avt_pkg::t_unit_res                  o_res
);

    logic signed [avt_pkg::YEAR_W:0] age;
    logic signed [avt_pkg::YEAR_W:0] limit;

    // signed age, one extra bit holds the sign
    assign age   = $signed({1'b0, i_cur_year}) - $signed({1'b0, i_rec.year});
    assign limit = $signed({1'b0, i_max_age});

    assign o_res.key_hit   = (i_rec.key == i_key);
    assign o_res.too_old   = (age > limit);
    // visit count sticks at all ones
    assign o_res.vcnt_next = (&i_rec.vcnt) ? i_rec.vcnt
                                           : i_rec.vcnt + avt_pkg::VCNT_W'(1);

endmodule

// ===== rtl/core/aging_visit_table.sv =====
// ----------------------------------------------------------------------------
// aging_visit_table
// Dense table of visitor records (key, last-visit year, visit count) with
// visit and purge operations, scanned one entry per cycle between purge moves.
// ----------------------------------------------------------------------------
// One item is worked at a time; s_axis_tready is high only while the block
// waits for an item, and a finished result may sit in the output register
// while the next item is taken. The single read port of the record memory
// sets the pace: one entry per cycle, but for purge moves. A visit reads the
// records in order from place 0, writes the visit year and bumped count back
// on a hit, and on a miss appends a new record unless the table is full. A
// purge checks each record; a removal copies the last record into the freed
// place, where it is checked again; an empty table answers without a read.
// A new result waits while an earlier one sits in the output register. No
// clearing pass runs after reset. The present year resets to 2016; the user
// writes it through the cfg channel while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module aging_visit_table #(
    parameter int ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beat
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // visitor_key[30:0], visit_year[46:31],
                                        // max_age[62:47], zero[63]
    input  logic [0:0]  s_axis_tuser,   // op[0]
    // result beat
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // status[1:0], removed_count[8:2],
                                        // entries_used[15:9]
    // present year write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_VCHECK,
        S_VMISS,
        S_PCHECK,
        S_PMOVE,
        S_RESP
    } t_state;

    t_state                          r_state, n_state;
    logic [CW-1:0]                   r_count, n_count;
    logic [CW-1:0]                   r_idx, n_idx;
    logic [CW-1:0]                   r_removed, n_removed;
    logic [avt_pkg::STAT_W-1:0]      r_status, n_status;
    logic                            r_mvalid, n_mvalid;
    logic [15:0]                     r_mdata, n_mdata;
    logic [avt_pkg::YEAR_W-1:0]      r_cur_year;
    logic [avt_pkg::KEY_W-1:0]       r_key;
    logic [avt_pkg::YEAR_W-1:0]      r_year;
    logic [avt_pkg::YEAR_W-1:0]      r_max;

    logic                            mem_we;
    logic [IW-1:0]                   mem_waddr;
    avt_pkg::t_rec                   mem_wdata;
    logic                            mem_re;
    logic [IW-1:0]                   mem_raddr;
    avt_pkg::t_rec                   mem_rdata;
    avt_pkg::t_unit_res              unit_res;

    logic                            in_beat;
    logic [CW-1:0]                   idx_nx;
    logic [CW-1:0]                   last;
    logic [CW+6:0]                   count_ext;
    logic [CW+6:0]                   removed_ext;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

    assign idx_nx      = r_idx + CW'(1);
    assign last        = r_count - CW'(1);
    assign count_ext   = {7'd0, r_count};
    assign removed_ext = {7'd0, r_removed};

    avt_mem #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    avt_unit u_unit (
        .i_rec      (mem_rdata),
        .i_key      (r_key),
        .i_cur_year (r_cur_year),
        .i_max_age  (r_max),
        .o_res      (unit_res)
    );

    // sequencer next state and memory control
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_removed = r_removed;
        n_status  = r_status;
        n_mvalid  = r_mvalid;
        n_mdata   = r_mdata;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;

        if (r_mvalid && m_axis_tready) begin
            n_mvalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_removed = '0;
                    n_idx     = '0;
                    n_status  = avt_pkg::ST_HIT;
                    if (r_count == '0) begin
                        n_state = (s_axis_tuser[0] == avt_pkg::OP_PURGE) ? S_RESP : S_VMISS;
                    end else begin
                        mem_re  = 1'b1;
                        n_state = (s_axis_tuser[0] == avt_pkg::OP_PURGE) ? S_PCHECK
                                                                         : S_VCHECK;
                    end
                end
            end
            S_VCHECK: begin
                if (unit_res.key_hit) begin
                    mem_we         = 1'b1;
                    mem_waddr      = r_idx[IW-1:0];
                    mem_wdata.key  = r_key;
                    mem_wdata.year = r_year;
                    mem_wdata.vcnt = unit_res.vcnt_next;
                    n_status       = avt_pkg::ST_HIT;
                    n_state        = S_RESP;
                end else if (idx_nx < r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_nx[IW-1:0];
                    n_idx     = idx_nx;
                end else begin
                    n_state = S_VMISS;
                end
            end
            S_VMISS: begin
                if (r_count == FULL_CNT) begin
                    n_status = avt_pkg::ST_FULL;
                end else begin
                    mem_we         = 1'b1;
                    mem_waddr      = r_count[IW-1:0];
                    mem_wdata.key  = r_key;
                    mem_wdata.year = r_year;
                    mem_wdata.vcnt = avt_pkg::VCNT_W'(1);
                    n_count        = r_count + CW'(1);
                    n_status       = avt_pkg::ST_NEW;
                end
                n_state = S_RESP;
            end
            S_PCHECK: begin
                if (unit_res.too_old) begin
                    // drop this entry, pull the last one in unless it is itself
                    n_count   = last;
                    n_removed = r_removed + CW'(1);
                    if (r_idx == last) begin
                        n_state = S_RESP;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = last[IW-1:0];
                        n_state   = S_PMOVE;
                    end
                end else if (idx_nx < r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_nx[IW-1:0];
                    n_idx     = idx_nx;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_PMOVE: begin
                // read data now holds the moved record, checked again next
                mem_we    = 1'b1;
                mem_waddr = r_idx[IW-1:0];
                mem_wdata = mem_rdata;
                n_state   = S_PCHECK;
            end
            S_RESP: begin
                if (!r_mvalid || m_axis_tready) begin
                    n_mvalid = 1'b1;
                    n_mdata  = {count_ext[6:0], removed_ext[6:0], r_status};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_idx      <= '0;
            r_removed  <= '0;
            r_status   <= avt_pkg::ST_HIT;
            r_mvalid   <= 1'b0;
            r_mdata    <= '0;
            r_cur_year <= avt_pkg::RESET_YEAR;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_removed <= n_removed;
            r_status  <= n_status;
            r_mvalid  <= n_mvalid;
            r_mdata   <= n_mdata;
            if (i_cfg_valid) begin
                r_cur_year <= i_cfg_data;
            end
        end
    end

    // item payload capture
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_key  <= s_axis_tdata[30:0];
            r_year <= s_axis_tdata[46:31];
            r_max  <= s_axis_tdata[62:47];
        end
    end

endmodule

// ===== rtl/core/avt_chk.sv =====
// ----------------------------------------------------------------------------
// avt_chk
// Port-level checks of the aging visit table, bound to the top level.
// ----------------------------------------------------------------------------
module avt_chk #(
    parameter int ENTRIES = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    localparam logic [6:0] FULL7 = 7'(ENTRIES);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // status is one of the three defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("undefined status code");

    // a full report only comes with a full table
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == 2'd2 |-> m_axis_tdata[15:9] == FULL7)
        else $error("table full reported with free entries");

    // an input beat starts work, so no new item is taken the next cycle
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

endmodule

bind aging_visit_table avt_chk #(
    .ENTRIES (ENTRIES)
) u_avt_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
